[hw/rtl/lhs_pkg.sv]
// lhs_pkg: widths, register indexes, steering codes, reset values and shared
// structs for the lane histogram steering unit
// no dependencies
package lhs_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CNT_W      = 8;
	localparam int WIN_W      = COL_W + 1;
	localparam int OFF_W      = COL_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = WIN_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_END     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CENTER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT    = 3'd7;

	// steering codes
	localparam logic [2:0] STEER_STRAIGHT   = 3'd0;
	localparam logic [2:0] STEER_RIGHT_NEAR = 3'd1;
	localparam logic [2:0] STEER_RIGHT_MID  = 3'd2;
	localparam logic [2:0] STEER_RIGHT_FAR  = 3'd3;
	localparam logic [2:0] STEER_LEFT_NEAR  = 3'd4;
	localparam logic [2:0] STEER_LEFT_MID   = 3'd5;
	localparam logic [2:0] STEER_LEFT_FAR   = 3'd6;

	// register reset values
	localparam logic [ROW_W-1:0] RST_BAND_TOP     = 8'd140;
	localparam logic [ROW_W-1:0] RST_BAND_ROWS    = 8'd80;
	localparam logic [WIN_W-1:0] RST_LEFT_END     = 10'd150;
	localparam logic [COL_W-1:0] RST_RIGHT_START  = 9'd250;
	localparam logic [WIN_W-1:0] RST_IMAGE_WIDTH  = 10'd400;
	localparam logic [COL_W-1:0] RST_FRAME_CENTER = 9'd188;
	localparam logic [COL_W-1:0] RST_NEAR_LIMIT   = 9'd10;
	localparam logic [COL_W-1:0] RST_FAR_LIMIT    = 9'd20;

	typedef struct packed {
		logic [ROW_W-1:0] band_top;
		logic [ROW_W-1:0] band_rows;
		logic [WIN_W-1:0] left_window_end;
		logic [COL_W-1:0] right_window_start;
		logic [WIN_W-1:0] image_width;
		logic [COL_W-1:0] frame_center;
		logic [COL_W-1:0] near_limit;
		logic [COL_W-1:0] far_limit;
	} cfg_t;

	// pixel word as held in the read stage
	typedef struct packed {
		logic             upd;
		logic             rel0;
		logic             last;
		logic             pix;
		logic             eof;
		logic             in_left;
		logic             in_right;
		logic [COL_W-1:0] col;
	} item_t;

	// updated column count handed to the peak tracker
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             in_left;
		logic             in_right;
		logic             eof;
		logic [COL_W-1:0] col;
		logic [CNT_W-1:0] cnt;
	} cnt_t;

	// peak snapshot taken at end of frame
	typedef struct packed {
		logic [CNT_W-1:0] lcnt;
		logic [COL_W-1:0] lcol;
		logic [CNT_W-1:0] rcnt;
		logic [COL_W-1:0] rcol;
	} peak_t;

endpackage

[hw/rtl/lhs_count_stage.sv]
// lhs_count_stage: column count memory with read-modify-write and forwarding
// depends on lhs_pkg
module lhs_count_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      accept,
	input  lhs_pkg::cfg_t             cfg,
	input  logic                      pixel_on,
	input  logic [lhs_pkg::COL_W-1:0] column,
	input  logic [lhs_pkg::ROW_W-1:0] row,
	input  logic                      end_of_frame,
	output lhs_pkg::cnt_t             cnt_o
);
	import lhs_pkg::*;

	logic [CNT_W-1:0] mem [MAX_WIDTH];

	logic [ROW_W-1:0] rel;
	logic             in_rows;
	logic             col_ok;
	item_t            item_d;
	item_t            item_s1;
	logic             v_s1;
	logic [CNT_W-1:0] rd_s1;
	logic             wr_v_q;
	logic [COL_W-1:0] wr_col_q;
	logic [CNT_W-1:0] wr_cnt_q;
	logic [CNT_W-1:0] base;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] cnt;
	logic             wr_en;

	always_comb begin
		rel     = row - cfg.band_top;
		in_rows = (row >= cfg.band_top) && (rel < cfg.band_rows);
		col_ok  = {1'b0, column} < cfg.image_width;
		item_d.upd      = in_rows && col_ok;
		item_d.rel0     = (rel == '0);
		item_d.last     = (rel == cfg.band_rows - 1'b1);
		item_d.pix      = pixel_on;
		item_d.eof      = end_of_frame;
		item_d.in_left  = {1'b0, column} < cfg.left_window_end;
		item_d.in_right = column >= cfg.right_window_start;
		item_d.col      = column;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			wr_v_q <= 1'b0;
		end else begin
			if (adv)
				v_s1 <= accept;
			if (wr_en)
				wr_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_s1 <= item_d;
		if (wr_en) begin
			wr_col_q <= item_s1.col;
			wr_cnt_q <= cnt;
		end
	end

	// read old data; a write in the same cycle is picked up by forwarding
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= mem[column];
		if (wr_en)
			mem[item_s1.col] <= cnt;
	end

	always_comb begin
		base  = (wr_v_q && wr_col_q == item_s1.col) ? wr_cnt_q : rd_s1;
		sum   = {1'b0, base} + {{CNT_W{1'b0}}, item_s1.pix};
		if (item_s1.rel0)
			cnt = {{(CNT_W-1){1'b0}}, item_s1.pix};
		else if (sum[CNT_W])
			cnt = '1;
		else
			cnt = sum[CNT_W-1:0];
		wr_en = v_s1 && item_s1.upd && adv;
	end

	always_comb begin
		cnt_o.valid    = v_s1 && item_s1.upd;
		cnt_o.last     = item_s1.last;
		cnt_o.in_left  = item_s1.in_left;
		cnt_o.in_right = item_s1.in_right;
		cnt_o.eof      = v_s1 && item_s1.eof;
		cnt_o.col      = item_s1.col;
		cnt_o.cnt      = cnt;
	end

endmodule

[hw/rtl/lhs_peak_track.sv]
// lhs_peak_track: first-maximum trackers for the left and right windows,
// snapshot at end of frame; depends on lhs_pkg
module lhs_peak_track (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  lhs_pkg::cnt_t  cnt_i,
	output logic           snap_v,
	output lhs_pkg::peak_t snap
);
	import lhs_pkg::*;

	logic [CNT_W-1:0] lcnt_q;
	logic [COL_W-1:0] lcol_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [COL_W-1:0] rcol_q;
	logic             lbest;
	logic             rbest;
	logic             snap_v_s2;
	peak_t            snap_s2;

	always_comb begin
		lbest = cnt_i.valid && cnt_i.last && cnt_i.in_left && (cnt_i.cnt > lcnt_q);
		rbest = cnt_i.valid && cnt_i.last && cnt_i.in_right && (cnt_i.cnt > rcnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q    <= '0;
			rcnt_q    <= '0;
			snap_v_s2 <= 1'b0;
		end else if (adv) begin
			snap_v_s2 <= cnt_i.eof;
			// end of frame clears the trackers after its own update
			if (cnt_i.eof) begin
				lcnt_q <= '0;
				rcnt_q <= '0;
			end else begin
				if (lbest)
					lcnt_q <= cnt_i.cnt;
				if (rbest)
					rcnt_q <= cnt_i.cnt;
			end
		end
	end

	// columns only count while their best count is nonzero
	always_ff @(posedge clk) begin
		if (adv && lbest)
			lcol_q <= cnt_i.col;
		if (adv && rbest)
			rcol_q <= cnt_i.col;
		if (adv && cnt_i.eof) begin
			snap_s2.lcnt <= lbest ? cnt_i.cnt : lcnt_q;
			snap_s2.lcol <= lbest ? cnt_i.col : lcol_q;
			snap_s2.rcnt <= rbest ? cnt_i.cnt : rcnt_q;
			snap_s2.rcol <= rbest ? cnt_i.col : rcol_q;
		end
	end

	assign snap_v = snap_v_s2;
	assign snap   = snap_s2;

endmodule

[hw/rtl/lhs_steer.sv]
// lhs_steer: lane midpoint, offset, steering code and output register
// depends on lhs_pkg
module lhs_steer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lhs_pkg::cfg_t                    cfg,
	input  logic                             snap_v,
	input  lhs_pkg::peak_t                   snap,
	input  logic                             out_stall,
	output logic                             hold,
	output logic                             out_valid,
	output logic        [lhs_pkg::COL_W-1:0] left_lane,
	output logic        [lhs_pkg::COL_W-1:0] right_lane,
	output logic        [lhs_pkg::COL_W-1:0] lane_center,
	output logic signed [lhs_pkg::OFF_W-1:0] center_offset,
	output logic        [2:0]                steer_code
);
	import lhs_pkg::*;

	logic [COL_W-1:0]        l;
	logic [COL_W-1:0]        r;
	logic signed [OFF_W-1:0] d;
	logic signed [OFF_W-1:0] half;
	logic [COL_W-1:0]        center;
	logic                    adv;
	logic                    v_s3;
	logic [COL_W-1:0]        l_s3;
	logic [COL_W-1:0]        r_s3;
	logic [COL_W-1:0]        center_s3;
	logic signed [OFF_W-1:0] off;
	logic [OFF_W-1:0]        mag;
	logic [2:0]              code;
	logic                    out_valid_q;
	logic [COL_W-1:0]        left_q;
	logic [COL_W-1:0]        right_q;
	logic [COL_W-1:0]        center_q;
	logic signed [OFF_W-1:0] offset_q;
	logic [2:0]              code_q;

	// empty window falls back to column 0 on the left, window start on the right
	always_comb begin
		l      = (snap.lcnt != '0) ? snap.lcol : '0;
		r      = (snap.rcnt != '0) ? snap.rcol : cfg.right_window_start;
		d      = $signed({1'b0, r}) - $signed({1'b0, l});
		// halve toward zero
		half   = (d + $signed({{(OFF_W-1){1'b0}}, d[OFF_W-1]})) >>> 1;
		center = l + half[COL_W-1:0];
	end

	assign hold = v_s3 && out_valid_q && out_stall;
	assign adv  = !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				v_s3 <= snap_v;
			if (v_s3 && adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		off = $signed({1'b0, center_s3}) - $signed({1'b0, cfg.frame_center});
		mag = off[OFF_W-1] ? -off : off;
		if (off == '0)
			code = STEER_STRAIGHT;
		else if (mag[COL_W-1:0] >= cfg.far_limit)
			code = off[OFF_W-1] ? STEER_LEFT_FAR : STEER_RIGHT_FAR;
		else if (mag[COL_W-1:0] >= cfg.near_limit)
			code = off[OFF_W-1] ? STEER_LEFT_MID : STEER_RIGHT_MID;
		else
			code = off[OFF_W-1] ? STEER_LEFT_NEAR : STEER_RIGHT_NEAR;
	end

	always_ff @(posedge clk) begin
		if (adv && snap_v) begin
			l_s3      <= l;
			r_s3      <= r;
			center_s3 <= center;
		end
		if (v_s3 && adv) begin
			left_q   <= l_s3;
			right_q  <= r_s3;
			center_q <= center_s3;
			offset_q <= off;
			code_q   <= code;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_lane     = left_q;
	assign right_lane    = right_q;
	assign lane_center   = center_q;
	assign center_offset = offset_q;
	assign steer_code    = code_q;

endmodule

[hw/rtl/lane_histogram_steering_unit.sv]
// Lane histogram steering unit: takes one mask pixel word per clock in raster
// order unless stalled and counts set pixels per column over a row band in a
// 512 x 8 count memory (one read and one write port, read-modify-write with
// forwarding of the last write, so a column may repeat on consecutive words).
// Counts are loaded, not added, on the band's first row, so no clearing pass
// is needed and counts read before a column's first band row are undefined.
// On the band's last row each final count is compared against the best so
// far in the left and right windows. A frame's result passes the read stage,
// peak snapshot, steering stage and output register. in_stall is raised only
// while a finished result waits in the last pipeline stage and the output
// register holds an untaken, stalled word. The user must write registers
// via cfg_write / cfg_index / cfg_data while idle; it is not enforced.
// depends on lhs_pkg, lhs_count_stage, lhs_peak_track, lhs_steer
module lane_histogram_steering_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic        [lhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [lhs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 pixel_on,
	input  logic        [lhs_pkg::COL_W-1:0]     column,
	input  logic        [lhs_pkg::ROW_W-1:0]     row,
	input  logic                                 end_of_frame,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [lhs_pkg::COL_W-1:0]     left_lane,
	output logic        [lhs_pkg::COL_W-1:0]     right_lane,
	output logic        [lhs_pkg::COL_W-1:0]     lane_center,
	output logic signed [lhs_pkg::OFF_W-1:0]     center_offset,
	output logic        [2:0]                    steer_code
);
	import lhs_pkg::*;

	cfg_t  cfg_q;
	cnt_t  cnt_w;
	peak_t snap_w;
	logic  snap_v;
	logic  hold;
	logic  adv;
	logic  accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_top           <= RST_BAND_TOP;
			cfg_q.band_rows          <= RST_BAND_ROWS;
			cfg_q.left_window_end    <= RST_LEFT_END;
			cfg_q.right_window_start <= RST_RIGHT_START;
			cfg_q.image_width        <= RST_IMAGE_WIDTH;
			cfg_q.frame_center       <= RST_FRAME_CENTER;
			cfg_q.near_limit         <= RST_NEAR_LIMIT;
			cfg_q.far_limit          <= RST_FAR_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BAND_TOP:     cfg_q.band_top           <= cfg_data[ROW_W-1:0];
				REG_BAND_ROWS:    cfg_q.band_rows          <= cfg_data[ROW_W-1:0];
				REG_LEFT_END:     cfg_q.left_window_end    <= cfg_data[WIN_W-1:0];
				REG_RIGHT_START:  cfg_q.right_window_start <= cfg_data[COL_W-1:0];
				REG_IMAGE_WIDTH:  cfg_q.image_width        <= cfg_data[WIN_W-1:0];
				REG_FRAME_CENTER: cfg_q.frame_center       <= cfg_data[COL_W-1:0];
				REG_NEAR_LIMIT:   cfg_q.near_limit         <= cfg_data[COL_W-1:0];
				REG_FAR_LIMIT:    cfg_q.far_limit          <= cfg_data[COL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = !hold;
	assign in_stall = hold;
	assign accept   = in_valid && adv;

	lhs_count_stage u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.accept       (accept),
		.cfg          (cfg_q),
		.pixel_on     (pixel_on),
		.column       (column),
		.row          (row),
		.end_of_frame (end_of_frame),
		.cnt_o        (cnt_w)
	);

	lhs_peak_track u_peak (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cnt_i  (cnt_w),
		.snap_v (snap_v),
		.snap   (snap_w)
	);

	lhs_steer u_steer (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.snap_v        (snap_v),
		.snap          (snap_w),
		.out_stall     (out_stall),
		.hold          (hold),
		.out_valid     (out_valid),
		.left_lane     (left_lane),
		.right_lane    (right_lane),
		.lane_center   (lane_center),
		.center_offset (center_offset),
		.steer_code    (steer_code)
	);

endmodule

[hw/rtl/lhs_checker.sv]
// lhs_checker: port-level checks on the result channel of the lane
// histogram steering unit, bound to the top level; depends on lhs_pkg
module lhs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic        [lhs_pkg::COL_W-1:0] left_lane,
	input logic        [lhs_pkg::COL_W-1:0] right_lane,
	input logic        [lhs_pkg::COL_W-1:0] lane_center,
	input logic signed [lhs_pkg::OFF_W-1:0] center_offset,
	input logic        [2:0]                steer_code
);
	import lhs_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(steer_code) && $stable(center_offset)
			&& $stable(lane_center))
		else $error("stalled result word changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> steer_code != 3'd7)
		else $error("steering code out of range");

	a_straight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((steer_code == STEER_STRAIGHT) == (center_offset == '0)))
		else $error("straight code does not match zero offset");

	a_center_between: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((left_lane <= lane_center && lane_center <= right_lane)
			|| (right_lane <= lane_center && lane_center <= left_lane)))
		else $error("lane center outside the two peaks");

endmodule

bind lane_histogram_steering_unit lhs_checker u_lhs_checker (.*);
